// ----- hw/rtl/atrpv_pkg.sv -----
package atrpv_pkg;

  localparam int BC_W         = 6;
  localparam int MAX_ATR_LEN  = 34;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] TS_DIRECT    = 8'h3B;
  localparam logic [7:0] TS_INVERSE   = 8'h3F;
  localparam logic [7:0] TA1_DEFAULT  = 8'h11;
  localparam logic [7:0] TC2_DEFAULT  = 8'h0A;
  localparam logic [7:0] TB3_DEFAULT  = 8'hFF;
  localparam logic [7:0] TC2_ONE      = 8'h01;
  localparam logic [7:0] TC2_TEN      = 8'h0A;
  localparam logic [7:0] TC2_TWENTY   = 8'h14;
  localparam logic [7:0] TC1_T1_MAX   = 8'h1E;
  localparam logic [7:0] TC1_NONE     = 8'hFF;
  localparam logic [7:0] TA3_MAX      = 8'hFF;
  localparam logic [7:0] TA3_MIN_BAD  = 8'h0F;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_TS     = 4'd1,
    ST_TOO_LONG   = 4'd2,
    ST_BAD_TA1    = 4'd3,
    ST_BAD_TB1    = 4'd4,
    ST_BAD_TD1    = 4'd5,
    ST_BAD_TA2    = 4'd6,
    ST_BAD_TC2    = 4'd7,
    ST_BAD_TD2    = 4'd8,
    ST_BAD_TA3    = 4'd9,
    ST_BAD_TB3    = 4'd10,
    ST_BAD_TC3    = 4'd11,
    ST_BAD_TCK    = 4'd12,
    ST_INCOMPLETE = 4'd13
  } status_t;

  typedef enum logic [1:0] {
    KIND_TA = 2'd0,
    KIND_TB = 2'd1,
    KIND_TC = 2'd2,
    KIND_TD = 2'd3
  } kind_t;

  localparam logic [1:0] GRP_1 = 2'd0;
  localparam logic [1:0] GRP_2 = 2'd1;
  localparam logic [1:0] GRP_3 = 2'd2;

  typedef struct packed {
    status_t    status;
    logic [7:0] ta1;
    logic       ta2_seen;
    logic       ta2_bit4;
    logic [7:0] tc1;
    logic [7:0] tc2;
    logic [7:0] tb3;
    logic [7:0] td1;
    logic       td1_seen;
    logic [7:0] tck;
  } job_t;

endpackage

// ----- hw/rtl/atrpv_front.sv -----
module atrpv_front #(
  parameter int MAX_ATR_LEN = atrpv_pkg::MAX_ATR_LEN
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cold_reset,
  input  logic             byte_acc,
  input  logic [7:0]       atr_byte,
  input  logic             last_byte,
  output logic             job_push,
  output atrpv_pkg::job_t  job
);
  import atrpv_pkg::*;

  logic [BC_W-1:0] bc_r, bc_nxt;
  logic            over_r, over_nxt;
  logic [1:0]      gi_r, gi_nxt;
  logic [3:0]      pend_r, pend_nxt;
  logic            more_r, more_nxt;
  logic [7:0]      tck_r, tck_nxt;
  logic [7:0]      ta1_r, ta1_nxt;
  logic            ta2_seen_r, ta2_seen_nxt;
  logic            ta2_bit4_r, ta2_bit4_nxt;
  logic [7:0]      tc1_r, tc1_nxt;
  logic [7:0]      tc2_r, tc2_nxt;
  logic [7:0]      tb3_r, tb3_nxt;
  logic [7:0]      td1_r, td1_nxt;
  logic            td1_seen_r, td1_seen_nxt;
  status_t         fe_r, fe_nxt;

  kind_t           kind;
  logic [3:0]      pend_clr;
  logic [3:0]      lo;

  always_comb begin
    if (pend_r[0]) begin
      kind = KIND_TA;
    end else if (pend_r[1]) begin
      kind = KIND_TB;
    end else if (pend_r[2]) begin
      kind = KIND_TC;
    end else begin
      kind = KIND_TD;
    end
  end

  assign lo       = atr_byte[3:0];
  assign pend_clr = pend_r & ~(4'b0001 << kind);

  always_comb begin
    bc_nxt       = bc_r;
    over_nxt     = over_r;
    gi_nxt       = gi_r;
    pend_nxt     = pend_r;
    more_nxt     = more_r;
    tck_nxt      = tck_r;
    ta1_nxt      = ta1_r;
    ta2_seen_nxt = ta2_seen_r;
    ta2_bit4_nxt = ta2_bit4_r;
    tc1_nxt      = tc1_r;
    tc2_nxt      = tc2_r;
    tb3_nxt      = tb3_r;
    td1_nxt      = td1_r;
    td1_seen_nxt = td1_seen_r;
    fe_nxt       = fe_r;
    if (byte_acc) begin
      if (bc_r == '0) begin
        if (atr_byte != TS_DIRECT && atr_byte != TS_INVERSE) begin
          fe_nxt = ST_BAD_TS;
        end else begin
          more_nxt = 1'b1;
        end
      end else begin
        tck_nxt = tck_r ^ atr_byte;
        if (fe_r == ST_OK && more_r) begin
          if (bc_r == BC_W'(1)) begin
            pend_nxt = atr_byte[7:4];
            gi_nxt   = GRP_1;
            more_nxt = |atr_byte[7:4];
          end else begin
            pend_nxt = pend_clr;
            case (gi_r)
              GRP_1: begin
                case (kind)
                  KIND_TA: ta1_nxt = atr_byte;
                  KIND_TB: begin
                    if (cold_reset && atr_byte != 8'd0) fe_nxt = ST_BAD_TB1;
                  end
                  KIND_TC: tc1_nxt = atr_byte;
                  default: begin
                    td1_seen_nxt = 1'b1;
                    td1_nxt      = atr_byte;
                    if (lo > 4'd1) fe_nxt = ST_BAD_TD1;
                  end
                endcase
              end
              GRP_2: begin
                case (kind)
                  KIND_TA: begin
                    ta2_seen_nxt = 1'b1;
                    ta2_bit4_nxt = atr_byte[4];
                  end
                  KIND_TB: ;
                  KIND_TC: begin
                    if (atr_byte != TC2_ONE && atr_byte != TC2_TEN &&
                        atr_byte != TC2_TWENTY) begin
                      fe_nxt = ST_BAD_TC2;
                    end else begin
                      tc2_nxt = atr_byte;
                    end
                  end
                  default: begin
                    if (lo != 4'd1 &&
                        !((lo == 4'hE || lo == 4'hF) && td1_seen_r && td1_r[3:0] == 4'd0)) begin
                      fe_nxt = ST_BAD_TD2;
                    end
                  end
                endcase
              end
              default: begin
                case (kind)
                  KIND_TA: begin
                    if (atr_byte == TA3_MAX || atr_byte <= TA3_MIN_BAD) fe_nxt = ST_BAD_TA3;
                  end
                  KIND_TB: tb3_nxt = atr_byte;
                  KIND_TC: begin
                    if (atr_byte != 8'd0) fe_nxt = ST_BAD_TC3;
                  end
                  default: ;
                endcase
              end
            endcase
            if (kind == KIND_TD && gi_r < GRP_3) begin
              pend_nxt = atr_byte[7:4];
              gi_nxt   = gi_r + 2'd1;
              more_nxt = |atr_byte[7:4];
            end else if (pend_clr == 4'd0) begin
              more_nxt = 1'b0;
            end
          end
        end
      end
      if (&bc_r) begin
        over_nxt = 1'b1;
      end else begin
        bc_nxt = bc_r + BC_W'(1);
      end
    end

    job.ta1      = ta1_nxt;
    job.ta2_seen = ta2_seen_nxt;
    job.ta2_bit4 = ta2_bit4_nxt;
    job.tc1      = tc1_nxt;
    job.tc2      = tc2_nxt;
    job.tb3      = tb3_nxt;
    job.td1      = td1_nxt;
    job.td1_seen = td1_seen_nxt;
    job.tck      = tck_nxt;
    if (over_nxt || bc_nxt > BC_W'(MAX_ATR_LEN)) begin
      job.status = ST_TOO_LONG;
    end else if (fe_nxt != ST_OK) begin
      job.status = fe_nxt;
    end else if (more_nxt) begin
      job.status = ST_INCOMPLETE;
    end else begin
      job.status = ST_OK;
    end
  end

  assign job_push = byte_acc && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || job_push) begin
      bc_r       <= '0;
      over_r     <= 1'b0;
      gi_r       <= GRP_1;
      pend_r     <= 4'd0;
      more_r     <= 1'b0;
      tck_r      <= 8'd0;
      ta1_r      <= TA1_DEFAULT;
      ta2_seen_r <= 1'b0;
      ta2_bit4_r <= 1'b0;
      tc1_r      <= 8'd0;
      tc2_r      <= TC2_DEFAULT;
      tb3_r      <= TB3_DEFAULT;
      td1_r      <= 8'd0;
      td1_seen_r <= 1'b0;
      fe_r       <= ST_OK;
    end else begin
      bc_r       <= bc_nxt;
      over_r     <= over_nxt;
      gi_r       <= gi_nxt;
      pend_r     <= pend_nxt;
      more_r     <= more_nxt;
      tck_r      <= tck_nxt;
      ta1_r      <= ta1_nxt;
      ta2_seen_r <= ta2_seen_nxt;
      ta2_bit4_r <= ta2_bit4_nxt;
      tc1_r      <= tc1_nxt;
      tc2_r      <= tc2_nxt;
      tb3_r      <= tb3_nxt;
      td1_r      <= td1_nxt;
      td1_seen_r <= td1_seen_nxt;
      fe_r       <= fe_nxt;
    end
  end

endmodule

// ----- hw/rtl/atrpv_queue.sv -----
module atrpv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  atrpv_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output atrpv_pkg::job_t  head_job
);
  import atrpv_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = cnt_r == CW'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/atrpv_back.sv -----
module atrpv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  atrpv_pkg::job_t  job,
  output logic             job_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [63:0]      out_tdata
);
  import atrpv_pkg::*;

  status_t     st;
  logic [1:0]  dsh;
  logic        ta1_ok;
  logic        prot;
  logic [3:0]  cwi;
  logic [3:0]  bwi;
  logic [8:0]  cw_lim;
  logic [17:0] tc2_scaled;
  logic [17:0] wwt;
  logic [16:0] bwt;
  logic [5:0]  cwt;
  logic [3:0]  di;

  logic        valid_r;
  status_t     st_r;
  logic        prot_r;
  logic [3:0]  fi_r;
  logic [3:0]  di_r;
  logic [7:0]  gt_r;
  logic [17:0] wwt_r;
  logic [5:0]  cwt_r;
  logic [16:0] bwt_r;

  always_comb begin
    ta1_ok = 1'b1;
    case (job.ta1[3:0])
      4'd1:       dsh = 2'd0;
      4'd2:       dsh = 2'd1;
      4'd3, 4'd4: dsh = 2'd2;
      4'd8:       dsh = 2'd3;
      default: begin
        dsh    = 2'd0;
        ta1_ok = 1'b0;
      end
    endcase
  end

  assign prot   = job.td1_seen && job.td1[0];
  assign cwi    = job.tb3[3:0];
  assign bwi    = job.tb3[7:4];
  assign cw_lim = (9'd1 << cwi) + 9'd11;

  always_comb begin
    st = job.status;
    if (st == ST_OK) begin
      if (job.td1_seen && (job.td1[3:0] != 4'd0 || job.td1[7]) && job.tck != 8'd0) begin
        st = ST_BAD_TCK;
      end else if (!ta1_ok) begin
        st = ST_BAD_TA1;
      end else if (job.ta2_seen && job.ta2_bit4) begin
        st = ST_BAD_TA2;
      end else if (prot) begin
        if (cwi > 4'd5 || bwi > 4'd4) begin
          st = ST_BAD_TB3;
        end else if (job.tc1 == 8'd0 && job.tb3 == 8'd0) begin
          st = ST_BAD_TB3;
        end else if (job.tc1 > TC1_T1_MAX && job.tc1 != TC1_NONE) begin
          st = ST_BAD_TB3;
        end else if (job.tc1 != TC1_NONE && cw_lim <= {1'b0, job.tc1} + 9'd1) begin
          st = ST_BAD_TB3;
        end
      end
    end
  end

  assign di         = job.ta2_seen ? (4'd1 << dsh) : 4'd1;
  assign tc2_scaled = 18'(job.tc2) * 18'd960 + 18'd480;
  assign wwt        = (job.ta2_seen ? (tc2_scaled << dsh) : tc2_scaled) + 18'd1;
  assign bwt        = (job.ta2_seen ? (((17'd960 << bwi) + 17'd960) << dsh)
                                    : ((17'd960 << bwi) + 17'd960)) + 17'd11;
  assign cwt        = (6'd1 << cwi) + 6'd15;

  assign job_pop = job_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (job_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      st_r <= st;
      if (st != ST_OK) begin
        prot_r <= 1'b0;
        fi_r   <= 4'd0;
        di_r   <= 4'd1;
        gt_r   <= 8'd0;
        wwt_r  <= 18'd0;
        cwt_r  <= 6'd0;
        bwt_r  <= 17'd0;
      end else begin
        prot_r <= prot;
        fi_r   <= job.ta1[7:4];
        di_r   <= di;
        gt_r   <= job.tc1;
        wwt_r  <= wwt;
        cwt_r  <= prot ? cwt : 6'd0;
        bwt_r  <= prot ? bwt : 17'd0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, bwt_r, cwt_r, wwt_r, gt_r, di_r, fi_r, prot_r, st_r};

endmodule

// ----- hw/rtl/atr_parse_and_validate_unit.sv -----
// Channel  | Ports                                 | Contents
// in_      | in_tvalid/in_tready/in_tdata/in_tlast | one ATR byte, in_tlast on the last one
// out_     | out_tvalid/out_tready/out_tdata       | one result per ATR, sent after its final byte
// cfg_     | cfg_wr_en/cfg_wr_data                 | cold_reset flag
//
// Bytes are parsed as they are accepted, one byte per cycle unless the queue is full.
// The result enters the job queue with the final byte, then the output register.
// A two-entry job queue sits between parser and result stage, so in_tready drops only
// when the queue is full while the output is stalled.
// Reset is synchronous and active low; it clears the parser, the queue and the output.
module atr_parse_and_validate_unit #(
  parameter int MAX_ATR_LEN = atrpv_pkg::MAX_ATR_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] atr_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [3:0] status, [4] protocol, [8:5] clock_rate_index,
                                  // [12:9] baud_divisor, [20:13] guard_time,
                                  // [38:21] work_wait_time, [44:39] char_wait_time,
                                  // [61:45] block_wait_time, [63:62] zero
);
  import atrpv_pkg::*;

  logic cold_reset_r;
  logic byte_acc;
  logic job_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t push_job;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cold_reset_r <= 1'b1;
    end else if (cfg_wr_en) begin
      cold_reset_r <= cfg_wr_data;
    end
  end

  assign in_tready = !q_full;
  assign byte_acc  = in_tvalid && in_tready;

  atrpv_front #(
    .MAX_ATR_LEN(MAX_ATR_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cold_reset(cold_reset_r),
    .byte_acc  (byte_acc),
    .atr_byte  (in_tdata),
    .last_byte (in_tlast),
    .job_push  (job_push),
    .job       (push_job)
  );

  atrpv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_job  (head_job)
  );

  atrpv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (head_job),
    .job_pop   (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// ----- hw/rtl/atrpv_checker.sv -----
module atrpv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  logic err_result;
  logic ok_result;

  assign err_result = out_tvalid && out_tdata[3:0] != 4'd0;
  assign ok_result  = out_tvalid && out_tdata[3:0] == 4'd0;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    err_result |-> out_tdata[8:4] == 5'd0 && out_tdata[12:9] == 4'd1 &&
                   out_tdata[63:13] == 51'd0)
    else $error("error result carries nonzero timing fields");

  a_ok_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    ok_result |-> out_tdata[12:9] == 4'd1 || out_tdata[12:9] == 4'd2 ||
                  out_tdata[12:9] == 4'd4 || out_tdata[12:9] == 4'd8)
    else $error("baud divisor is not a power of two");

  a_t0_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ok_result && !out_tdata[4] |-> out_tdata[61:39] == 23'd0)
    else $error("T=0 result carries T=1 wait times");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind atr_parse_and_validate_unit atrpv_checker u_atrpv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
